// File: hw/rtl/tsrr_pkg.sv
`timescale 1ns / 1ps

package tsrr_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IDX_W      = 3;
  localparam int CMP_W      = ((SLOT_W > IDX_W) ? SLOT_W : IDX_W) + 1;
  localparam int SUM_W      = SLOT_W + 1;
  localparam int TGT_W      = 64;
  localparam int FLAG_W     = 32;

  localparam logic [3:0] ACTIVE_MASK = 4'hF;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_CMD,
    KIND_TABLE
  } res_kind_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// File: hw/rtl/task_slot_round_robin_picker.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Word
// in_      input      in_valid/in_ready    req_type, target_context, slot_index,
//                                          activity_flags, current_slot
// out_     output     out_valid/out_ready  switch_target
//
// Each word passes through a calc state, which updates the slot table and runs the
// rotating-priority search, and a load state, which fetches the chosen target into the output register.
// The next word is taken in the load state when the output register is free.
// Synchronous active-low reset marks every slot inactive.
// A stalled output holds the controller in its load state until out_ready.

module task_slot_round_robin_picker import tsrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [TGT_W-1:0]  in_target_context,
  input  logic [IDX_W-1:0]  in_slot_index,
  input  logic [FLAG_W-1:0] in_activity_flags,
  input  logic [IDX_W-1:0]  in_current_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TGT_W-1:0]  out_switch_target
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsrr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req_type),
    .in_target_context (in_target_context),
    .in_slot_index     (in_slot_index),
    .in_activity_flags (in_activity_flags),
    .in_current_slot   (in_current_slot),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_switch_target (out_switch_target)
  );

endmodule

// File: hw/rtl/tsrr_ctrl.sv
`timescale 1ns / 1ps

module tsrr_ctrl import tsrr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // A new word may enter while the previous result moves to the output register.
  assign in_ready    = rst_n &&
                       ((state_r == ST_IDLE) || ((state_r == ST_LOAD) && stat.out_free));
  assign cmd.capture = in_valid && in_ready;
  assign cmd.calc    = (state_r == ST_CALC);
  assign cmd.load    = (state_r == ST_LOAD) && stat.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.capture) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat.out_free) state_nxt = cmd.capture ? ST_CALC : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/tsrr_dp.sv
`timescale 1ns / 1ps

module tsrr_dp import tsrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              in_req_type,
  input  logic [TGT_W-1:0]  in_target_context,
  input  logic [IDX_W-1:0]  in_slot_index,
  input  logic [FLAG_W-1:0] in_activity_flags,
  input  logic [IDX_W-1:0]  in_current_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TGT_W-1:0]  out_switch_target
);

  logic              req_r;
  logic [TGT_W-1:0]  tgt_r;
  logic [IDX_W-1:0]  idx_r;
  logic              act_in_r;
  logic [IDX_W-1:0]  cur_r;

  logic [SLOT_COUNT-1:0] active_r;
  logic [TGT_W-1:0]      tgt_tab_r [SLOT_COUNT];

  res_kind_t         kind_r;
  res_kind_t         kind_nxt;
  logic [SLOT_W-1:0] pick_r;
  logic [SLOT_W-1:0] pick_nxt;

  logic              out_valid_r;
  logic [TGT_W-1:0]  out_target_r;

  logic [CMP_W-1:0]        idx_ext;
  logic [CMP_W-1:0]        cur_ext;
  logic                    idx_ok;
  logic                    cur_ok;
  logic [SLOT_W-1:0]       idx_slot;
  logic [SLOT_W-1:0]       cur_slot;
  logic [SLOT_W-1:0]       start;
  logic [SLOT_COUNT-1:0]   excl;
  logic [SLOT_COUNT-1:0]   act_m;
  logic [2*SLOT_COUNT-1:0] dbl_sh;
  logic [SLOT_COUNT-1:0]   rot;
  logic [SLOT_W-1:0]       off;
  logic                    hit;
  logic [SUM_W-1:0]        sum;
  logic                    tgt_nz;

  assign stat.out_free     = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_switch_target = out_target_r;

  assign idx_ext  = CMP_W'(idx_r);
  assign cur_ext  = CMP_W'(cur_r);
  assign idx_ok   = idx_ext < CMP_W'(SLOT_COUNT);
  assign cur_ok   = cur_ext < CMP_W'(SLOT_COUNT);
  assign idx_slot = idx_ext[SLOT_W-1:0];
  assign cur_slot = cur_ext[SLOT_W-1:0];
  assign tgt_nz   = (tgt_r != '0);

  // The scan starts after the running slot and never returns it; with the
  // running slot out of range it covers every slot from zero.
  assign start  = !cur_ok ? '0 :
                  (cur_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : cur_slot + 1'b1;
  assign excl   = cur_ok ? (SLOT_COUNT'(1) << cur_slot) : '0;
  assign act_m  = active_r & ~excl;
  assign dbl_sh = {act_m, act_m} >> start;
  assign rot    = dbl_sh[SLOT_COUNT-1:0];
  assign hit    = |rot;

  always_comb begin
    off = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (rot[i]) off = SLOT_W'(i);
    end
  end

  assign sum = SUM_W'(start) + SUM_W'(off);

  always_comb begin
    if (sum >= SUM_W'(SLOT_COUNT)) begin
      pick_nxt = SLOT_W'(sum - SUM_W'(SLOT_COUNT));
    end else begin
      pick_nxt = sum[SLOT_W-1:0];
    end
  end

  always_comb begin
    if (!req_r) begin
      kind_nxt = KIND_ZERO;
    end else if (tgt_nz) begin
      kind_nxt = act_in_r ? KIND_CMD : KIND_ZERO;
    end else begin
      kind_nxt = hit ? KIND_TABLE : KIND_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= in_req_type;
      tgt_r    <= in_target_context;
      idx_r    <= in_slot_index;
      act_in_r <= |(in_activity_flags[3:0] & ACTIVE_MASK);
      cur_r    <= in_current_slot;
    end
    if (cmd.calc) begin
      kind_r <= kind_nxt;
      pick_r <= pick_nxt;
      if (req_r && tgt_nz && idx_ok) begin
        tgt_tab_r[idx_slot] <= tgt_r;
      end
    end
    if (cmd.load) begin
      case (kind_r)
        KIND_CMD:   out_target_r <= tgt_r;
        KIND_TABLE: out_target_r <= tgt_tab_r[pick_r];
        default:    out_target_r <= '0;
      endcase
    end
  end

  // Only the active bits need reset: a target is read only behind its active bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.calc && req_r && tgt_nz && idx_ok) begin
        active_r[idx_slot] <= act_in_r;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
